/* hw/rtl/hfi_rotor_angle_estimator_macros.svh */
// Assertion helpers used by the estimator RTL.
`ifndef HFI_ROTOR_ANGLE_ESTIMATOR_MACROS_SVH
`define HFI_ROTOR_ANGLE_ESTIMATOR_MACROS_SVH
// Checks that a condition implies a consequence on the same edge.
`define HRAE_ASSERT_IMPLY(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);
// Checks that a condition implies a consequence on the next edge.
`define HRAE_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);
`endif

/* hw/rtl/hrae_pkg.sv */
package hrae_pkg;
   localparam int GAIN_SHIFT_DEF = 16;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int POLY_A = 51472;
   localparam int POLY_B = 21024;
   localparam int POLY_C = 2320;
   localparam logic [2:0] CSR_HALF_PERIOD = 3'd0;
   localparam logic [2:0] CSR_PROP_GAIN = 3'd1;
   localparam logic [2:0] CSR_INTEG_GAIN = 3'd2;
   localparam logic [2:0] CSR_INTEG_LIMIT = 3'd3;
   localparam logic [2:0] CSR_INJECT_AMP = 3'd4;
   typedef struct packed {
      logic        start;
      logic [33:0] a;
      logic [33:0] b;
   } mul_req_type;
endpackage

/* hw/rtl/hrae_serial_mul.sv */
module hrae_serial_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  hrae_pkg::mul_req_type req,
   output logic                 done,
   output logic signed [67:0]   product
);
   // Signed radix-2 shift-add: one multiplier bit per cycle.
   logic [5:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [67:0] mcand_ff, mcand_in;
   logic [33:0] mplier_ff, mplier_in;
   logic done_ff, done_in;

   always_comb begin
      count_in = count_ff;
      busy_in = busy_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         count_in = 6'd0;
         acc_in = '0;
         mcand_in = {{34{req.a[33]}}, req.a};
         mplier_in = req.b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            if (count_ff == 6'd33) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd33) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

/* hw/rtl/hfi_rotor_angle_estimator.sv */
// Sequence from an input beat to rsp_tvalid: seventeen products (each a start, one serial
// step per multiplier bit, done), two steps that finish the sine and cosine, one load.
// Samples do not overlap: the next sample is taken once the previous one has reached the
// result register, and a result still waiting there holds the next one in ST_PUSH.
// Reset is synchronous and active high; it restores register defaults
// (half period one, all else zero) and clears the observer state.
module hfi_rotor_angle_estimator #(
   parameter int GAIN_SHIFT = hrae_pkg::GAIN_SHIFT_DEF,
   parameter int SINE_TABLE_BITS = hrae_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: cur_alpha[15:0], cur_beta[31:16].
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: volt_alpha[15:0], volt_beta[31:16], speed_est[63:32],
   // angle_est[79:64].
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
`include "hfi_rotor_angle_estimator_macros.svh"

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_MUL = 5'd1;
   localparam logic [4:0] ST_WAIT = 5'd2;
   localparam logic [4:0] ST_OUT = 5'd3;
   localparam logic [4:0] ST_PUSH = 5'd4;

   // Sequence of product steps.
   localparam logic [3:0] SQ_SX2 = 4'd0, SQ_ST1 = 4'd1, SQ_ST2 = 4'd2, SQ_ST3 = 4'd3;
   localparam logic [3:0] SQ_CX2 = 4'd4, SQ_CT1 = 4'd5, SQ_CT2 = 4'd6, SQ_CT3 = 4'd7;
   localparam logic [3:0] SQ_SC = 4'd8, SQ_CC = 4'd9, SQ_SS = 4'd10;
   localparam logic [3:0] SQ_EA = 4'd11, SQ_EB = 4'd12, SQ_PR = 4'd13, SQ_IN = 4'd14;
   localparam logic [3:0] SQ_VA = 4'd15;
   localparam logic [15:0] ANG_MASK = 16'hFFFF << (16 - SINE_TABLE_BITS);

   logic [15:0] half_ff, pgain_ff, igain_ff;
   logic [30:0] ilim_ff;
   logic [14:0] amp_ff;
   logic [15:0] tick_ff;
   logic        pol_ff;
   logic signed [15:0] last_a_ff, last_b_ff;
   logic [15:0] angle_ff;
   logic signed [33:0] integ_ff;
   logic [4:0]  state_ff;
   logic [3:0]  step_ff;
   logic        vb_ff;
   logic signed [16:0] hfa_ff, hfb_ff;
   logic [16:0] x_ff;
   logic [1:0]  q_ff;
   logic [31:0] x2_ff, t_ff;
   logic signed [16:0] s_ff, c_ff;
   logic signed [33:0] sc_ff, cc_ff, err_ff, prop_ff;
   logic signed [15:0] va_ff;
   logic [79:0] out_ff;
   logic        out_v_ff, out_v_in;
   logic        out_load;

   hrae_pkg::mul_req_type mreq;
   logic mdone;
   logic signed [67:0] mprod;

   hrae_serial_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .done(mdone),
      .product(mprod));

   // Quarter-wave argument for the sine or cosine phase.
   logic [15:0] ph_s, ph_c;
   assign ph_s = angle_ff & ANG_MASK;
   assign ph_c = (angle_ff + 16'h4000) & ANG_MASK;
   function automatic logic [16:0] qarg(input logic [15:0] p);
      if (p[14]) qarg = {2'b00, 15'h0} + ((17'd16384 - {3'b0, p[13:0]}) << 1);
      else qarg = {2'b0, p[13:0], 1'b0};
   endfunction

   logic signed [67:0] spr;
   logic signed [33:0] p15, iq_sum, lim34, spd_sum, spd_sat;
   logic [16:0] tq;
   assign spr = mprod;
   assign p15 = 34'(spr >>> 15);
   assign lim34 = {3'b0, ilim_ff};

   logic [16:0] tick_nx;
   logic        flip;
   assign tick_nx = {1'b0, tick_ff} + 17'd1;
   assign flip = tick_nx >= {1'b0, half_ff};

   // The result register parts the two sides: a new sample may start while the
   // previous beat still waits, and the finished one is held in ST_PUSH until
   // the register frees up.
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;
   assign out_load = (state_ff == ST_PUSH) && (!out_v_ff || rsp_tready);
   assign out_v_in = out_load || (out_v_ff && !rsp_tready);

   always_comb begin
      mreq.start = 1'b0;
      mreq.a = '0;
      mreq.b = '0;
      if (state_ff == ST_MUL) begin
         mreq.start = 1'b1;
         case (step_ff)
            SQ_SX2, SQ_CX2: begin mreq.a = {17'b0, x_ff}; mreq.b = {17'b0, x_ff}; end
            SQ_ST1, SQ_CT1: begin
               mreq.a = 34'(hrae_pkg::POLY_C); mreq.b = {2'b0, x2_ff};
            end
            SQ_ST2, SQ_CT2: begin mreq.a = {2'b0, x2_ff}; mreq.b = {2'b0, t_ff}; end
            SQ_ST3, SQ_CT3: begin mreq.a = {17'b0, x_ff}; mreq.b = {2'b0, t_ff}; end
            SQ_SC: begin mreq.a = 34'(s_ff); mreq.b = 34'(c_ff); end
            SQ_CC: begin mreq.a = 34'(c_ff); mreq.b = 34'(c_ff); end
            SQ_SS: begin mreq.a = 34'(s_ff); mreq.b = 34'(s_ff); end
            SQ_EA: begin mreq.a = 34'(-hfa_ff); mreq.b = sc_ff; end
            SQ_EB: begin mreq.a = 34'(hfb_ff); mreq.b = cc_ff; end
            SQ_PR: begin mreq.a = err_ff; mreq.b = {18'b0, pgain_ff}; end
            SQ_IN: begin mreq.a = err_ff; mreq.b = {18'b0, igain_ff}; end
            default: begin
               mreq.a = pol_ff ? -34'(amp_ff) : 34'(amp_ff);
               mreq.b = vb_ff ? 34'(s_ff) : 34'(c_ff);
            end
         endcase
      end
   end

   assign tq = (t_ff > 32'd32767) ? 17'd32767 : t_ff[16:0];
   assign iq_sum = integ_ff + 34'(spr);
   assign spd_sum = prop_ff + integ_ff;
   assign spd_sat = (spd_sum > 34'sh7FFFFFFF) ? 34'sh7FFFFFFF :
                    (spd_sum < -34'sh80000000) ? -34'sh80000000 : spd_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 16'd1; pgain_ff <= '0; igain_ff <= '0; ilim_ff <= '0; amp_ff <= '0;
         tick_ff <= '0; pol_ff <= 1'b0; last_a_ff <= '0; last_b_ff <= '0;
         angle_ff <= '0; integ_ff <= '0; state_ff <= ST_IDLE; step_ff <= '0;
         out_v_ff <= 1'b0; vb_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hrae_pkg::CSR_HALF_PERIOD: half_ff <= csr_data[15:0];
               hrae_pkg::CSR_PROP_GAIN: pgain_ff <= csr_data[15:0];
               hrae_pkg::CSR_INTEG_GAIN: igain_ff <= csr_data[15:0];
               hrae_pkg::CSR_INTEG_LIMIT: ilim_ff <= csr_data[30:0];
               hrae_pkg::CSR_INJECT_AMP: amp_ff <= csr_data[14:0];
               default: ;
            endcase
         end
         out_v_ff <= out_v_in;
         case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               tick_ff <= flip ? 16'd0 : tick_nx[15:0];
               pol_ff <= flip ? !pol_ff : pol_ff;
               hfa_ff <= (flip ^ pol_ff) ?
                  17'sd0 - (17'(signed'(req_tdata[15:0])) - 17'(last_a_ff)) :
                  17'(signed'(req_tdata[15:0])) - 17'(last_a_ff);
               hfb_ff <= (flip ^ pol_ff) ?
                  17'sd0 - (17'(signed'(req_tdata[31:16])) - 17'(last_b_ff)) :
                  17'(signed'(req_tdata[31:16])) - 17'(last_b_ff);
               last_a_ff <= req_tdata[15:0];
               last_b_ff <= req_tdata[31:16];
               x_ff <= qarg(ph_s);
               q_ff <= ph_s[15:14];
               step_ff <= SQ_SX2;
               vb_ff <= 1'b0;
               state_ff <= ST_MUL;
            end
            ST_MUL: state_ff <= ST_WAIT;
            ST_WAIT: if (mdone) begin
               state_ff <= ST_MUL;
               step_ff <= step_ff + 4'd1;
               case (step_ff)
                  SQ_SX2, SQ_CX2: x2_ff <= 32'(spr >>> 15);
                  SQ_ST1, SQ_CT1: t_ff <= 32'(hrae_pkg::POLY_B) - 32'(spr >>> 15);
                  SQ_ST2, SQ_CT2: t_ff <= 32'(hrae_pkg::POLY_A) - 32'(spr >>> 15);
                  SQ_ST3: begin
                     t_ff <= 32'(spr >>> 15);
                     step_ff <= SQ_ST3; state_ff <= ST_OUT;
                  end
                  SQ_CT3: begin
                     t_ff <= 32'(spr >>> 15);
                     step_ff <= SQ_CT3; state_ff <= ST_OUT;
                  end
                  SQ_SC: sc_ff <= 34'(spr >>> 14);
                  SQ_CC: cc_ff <= 34'(spr);
                  SQ_SS: cc_ff <= 34'((68'(cc_ff) - spr) >>> 15);
                  SQ_EA: err_ff <= 34'(spr);
                  SQ_EB: err_ff <= 34'((68'(err_ff) + spr) >>> 15);
                  SQ_PR: prop_ff <= 34'(spr);
                  SQ_IN: integ_ff <= (iq_sum > lim34) ? lim34 :
                                     (iq_sum < -lim34) ? -lim34 : iq_sum;
                  default: begin
                     if (!vb_ff) begin
                        va_ff <= 16'(p15);
                        vb_ff <= 1'b1;
                        step_ff <= SQ_VA;
                     end else begin
                        // The beta product stays in the multiplier until loaded.
                        state_ff <= ST_PUSH;
                     end
                  end
               endcase
            end
            ST_OUT: begin
               // Finish a sine/cosine: cap, sign by quadrant.
               if (step_ff == SQ_ST3) begin
                  s_ff <= q_ff[1] ? -17'(tq) : 17'(tq);
                  x_ff <= qarg(ph_c);
                  q_ff <= ph_c[15:14];
                  step_ff <= SQ_CX2;
               end else begin
                  c_ff <= q_ff[1] ? -17'(tq) : 17'(tq);
                  step_ff <= SQ_SC;
               end
               state_ff <= ST_MUL;
            end
            ST_PUSH: if (out_load) begin
               out_ff <= {angle_ff + 16'(spd_sat >>> GAIN_SHIFT),
                          32'(spd_sat), 16'(p15), va_ff};
               angle_ff <= angle_ff + 16'(spd_sat >>> GAIN_SHIFT);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `HRAE_ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_tready,
      "input accepted while busy")
   `HRAE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result dropped before taken")
   `HRAE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready,
      $stable(rsp_tdata), "result changed while waiting")
   `HRAE_ASSERT_IMPLY(a_state_legal, clock, reset, 1'b1, state_ff <= ST_PUSH,
      "sequencer in an unknown state")
endmodule

/* sim/hfi_rotor_angle_checker.sv */
`timescale 1ns / 1ps

// Watches the sample, result and register channels, keeps its own copy of the
// observer state and compares every result beat with the predicted one.
module hfi_rotor_angle_checker #(
   parameter int GAIN_SHIFT = hrae_pkg::GAIN_SHIFT_DEF,
   parameter int SINE_TABLE_BITS = hrae_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic [15:0] volt_alpha;
      logic [15:0] volt_beta;
      logic [31:0] speed_est;
      logic [15:0] angle_est;
   } drive_beat_type;

   drive_beat_type expected_drive[$];

   // Register copies.
   int unsigned half_period;
   int unsigned prop_gain;
   int unsigned integ_gain;
   longint      integ_limit;
   int unsigned inject_amp;

   // Observer state.
   int unsigned tick_count;
   bit          polarity_neg;
   longint      prev_alpha;
   longint      prev_beta;
   bit [15:0]   rotor_angle;
   longint      pll_integ;

   function automatic longint poly_sine(int unsigned x);
      longint unsigned x2, t;
      x2 = (longint'(x) * x) >> 15;
      t = (hrae_pkg::POLY_C * x2) >> 15;
      t = hrae_pkg::POLY_B - t;
      t = (x2 * t) >> 15;
      t = hrae_pkg::POLY_A - t;
      t = (longint'(x) * t) >> 15;
      if (t > 32767) t = 32767;
      return longint'(t);
   endfunction

   function automatic longint angle_sine(bit [15:0] p);
      bit [1:0]    quadrant;
      int unsigned r, x;
      longint      y;
      p = p & ~16'((1 << (16 - SINE_TABLE_BITS)) - 1);
      quadrant = p[15:14];
      r = p[13:0];
      x = quadrant[0] ? (16384 - r) << 1 : r << 1;
      y = poly_sine(x);
      return quadrant[1] ? -y : y;
   endfunction

   // One control tick of the observer; pushes the expected drive beat.
   task automatic track_rotor(logic [31:0] sample);
      longint         ia, ib, hfa, hfb, s, c, s2, c2, err, spd, ud;
      drive_beat_type beat;
      ia = longint'($signed(sample[15:0]));
      ib = longint'($signed(sample[31:16]));
      tick_count = tick_count + 1;
      if (tick_count >= half_period) begin
         tick_count = 0;
         polarity_neg = !polarity_neg;
      end
      hfa = ia - prev_alpha;
      hfb = ib - prev_beta;
      if (polarity_neg) begin
         hfa = -hfa;
         hfb = -hfb;
      end
      prev_alpha = ia;
      prev_beta = ib;
      s = angle_sine(rotor_angle);
      c = angle_sine(rotor_angle + 16'd16384);
      s2 = (s * c) >>> 14;
      c2 = (c * c - s * s) >>> 15;
      err = (-hfa * s2 + hfb * c2) >>> 15;
      pll_integ = pll_integ + err * longint'(integ_gain);
      if (pll_integ > integ_limit) pll_integ = integ_limit;
      if (pll_integ < -integ_limit) pll_integ = -integ_limit;
      spd = err * longint'(prop_gain) + pll_integ;
      if (spd > 64'sd2147483647) spd = 64'sd2147483647;
      if (spd < -64'sd2147483648) spd = -64'sd2147483648;
      ud = polarity_neg ? -longint'(inject_amp) : longint'(inject_amp);
      beat.volt_alpha = 16'((ud * c) >>> 15);
      beat.volt_beta = 16'((ud * s) >>> 15);
      beat.speed_est = 32'(spd);
      rotor_angle = rotor_angle + 16'(spd >>> GAIN_SHIFT);
      beat.angle_est = rotor_angle;
      expected_drive.push_back(beat);
   endtask

   task automatic report_field(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("%t mismatch in %s: expected %0d, got %0d", $realtime, field, want, got);
   endtask

   assign outstanding = expected_drive.size();

   always @(posedge clock) begin
      drive_beat_type want;
      if (reset) begin
         half_period <= 1;
         prop_gain <= 0;
         integ_gain <= 0;
         integ_limit <= 0;
         inject_amp <= 0;
         tick_count = 0;
         polarity_neg = 0;
         prev_alpha = 0;
         prev_beta = 0;
         rotor_angle = 0;
         pll_integ = 0;
         expected_drive.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hrae_pkg::CSR_HALF_PERIOD: half_period <= csr_data[15:0];
               hrae_pkg::CSR_PROP_GAIN:   prop_gain <= csr_data[15:0];
               hrae_pkg::CSR_INTEG_GAIN:  integ_gain <= csr_data[15:0];
               hrae_pkg::CSR_INTEG_LIMIT: integ_limit <= longint'(csr_data[30:0]);
               hrae_pkg::CSR_INJECT_AMP:  inject_amp <= csr_data[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            track_rotor(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drive.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t result beat with no sample waiting", $realtime);
            end else begin
               want = expected_drive.pop_front();
               if (rsp_tdata[15:0] != want.volt_alpha)
                  report_field("volt_alpha", $signed(want.volt_alpha),
                               $signed(rsp_tdata[15:0]));
               if (rsp_tdata[31:16] != want.volt_beta)
                  report_field("volt_beta", $signed(want.volt_beta),
                               $signed(rsp_tdata[31:16]));
               if (rsp_tdata[63:32] != want.speed_est)
                  report_field("speed_est", $signed(want.speed_est),
                               $signed(rsp_tdata[63:32]));
               if (rsp_tdata[79:64] != want.angle_est)
                  report_field("angle_est", want.angle_est, rsp_tdata[79:64]);
            end
         end
      end
   end

endmodule

/* sim/hfi_rotor_angle_estimator_tb.sv */
`timescale 1ns / 1ps

// Drives current samples and register writes into the estimator, lets both
// channels stall in random bursts, and reports the verdict that the checker
// module reaches.
module hfi_rotor_angle_estimator_tb;

   // The watchdog allows several times the time that one result takes, plus the
   // longest stall and gap.
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 600;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // Fields from bit 0: cur_alpha[15:0], cur_beta[31:16].
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // Fields from bit 0: volt_alpha[15:0], volt_beta[31:16], speed_est[63:32],
   // angle_est[79:64].
   logic [79:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   int          mismatches;
   int          outstanding;
   int          quiet_cycles;
   bit          steady;         // no idling on either side in the last phase
   logic [15:0] drift_alpha;
   logic [15:0] drift_beta;

   hfi_rotor_angle_estimator dut (.*);

   hfi_rotor_angle_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // The receiver is ready or stalls in bursts of random length and random choice.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (steady || reset) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 18) - 1) @(posedge clock);
         end
      end
   end

   // Any accepted beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("hfi_rotor_angle_estimator_tb: errors");
            $finish;
         end
      end
   end

   // Valid stays high so that writes follow back to back; the caller lowers it.
   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Registers change only once the block has drained every pending result.
   task automatic program_loop(int unsigned half, int unsigned kp, int unsigned ki,
                               int unsigned limit, int unsigned amp);
      while (outstanding != 0) @(posedge clock);
      write_reg(hrae_pkg::CSR_HALF_PERIOD, half);
      write_reg(hrae_pkg::CSR_PROP_GAIN, kp);
      write_reg(hrae_pkg::CSR_INTEG_GAIN, ki);
      write_reg(hrae_pkg::CSR_INTEG_LIMIT, limit);
      write_reg(hrae_pkg::CSR_INJECT_AMP, amp);
      csr_valid <= 1'b0;
   endtask

   // Sends one sample beat; valid stays high afterward so back-to-back beats
   // need no second assignment. A random gap lowers it first.
   task automatic send_sample(logic [15:0] alpha, logic [15:0] beta);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {beta, alpha};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_samples();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a slowly moving current with random steps, so the PLL sees a
   // usable error; now and then a full-range jump.
   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0) begin
            drift_alpha = 16'($urandom);
            drift_beta = 16'($urandom);
         end else begin
            drift_alpha = drift_alpha + 16'($signed($urandom_range(0, 4095)) - 2048);
            drift_beta = drift_beta + 16'($signed($urandom_range(0, 4095)) - 2048);
         end
         send_sample(drift_alpha, drift_beta);
      end
      pause_samples();
   endtask

   function automatic int unsigned pick_extreme(int unsigned top);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      steady = 1'b0;
      quiet_cycles = 0;
      drift_alpha = '0;
      drift_beta = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A zero half-period flips the polarity on every tick; full-scale
      // currents and gains push the speed into saturation.
      program_loop(0, 65535, 65535, 32'h7FFF_FFFF, 32767);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'h8000, 16'h7FFF);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hFFFF, 16'h0001);
      send_sample(16'h8000, 16'h7FFF);
      pause_samples();

      // Let the count climb, then lower the half-period below it so that the
      // next tick flips and clears.
      program_loop(6, 40000, 300, 5000000, 16384);
      for (int n = 0; n < 4; n++) send_sample(16'(n * 9000), 16'(-n * 7000));
      pause_samples();
      program_loop(2, 40000, 300, 5000000, 16384);
      send_sample(16'h1234, 16'hEDCB);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'h8000, 16'h7FFF);
      pause_samples();

      // Zero gains and zero limit hold the angle still.
      program_loop(65535, 0, 0, 0, 0);
      for (int n = 0; n < 4; n++) send_sample(16'($urandom), 16'($urandom));
      pause_samples();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7) steady = 1'b1;
         program_loop($urandom_range(0, 3) == 0 ? pick_extreme(65535) : $urandom_range(0, 12),
                      pick_extreme(65535), pick_extreme(65535),
                      pick_extreme(32'h7FFF_FFFF), pick_extreme(32767));
         random_phase(204);
      end

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("hfi_rotor_angle_estimator_tb: clean");
      else
         $display("hfi_rotor_angle_estimator_tb: errors");
      $finish;
   end

endmodule
